>>> hw/rtl/lpt_pkg.sv
// lpt_pkg: shared types, constants and helpers for the page table age counter block
`timescale 1ns / 1ps

package lpt_pkg;

	// fixed field widths
	localparam int PAGE_W = 8;
	localparam int CNT_W16 = 16;
	localparam int SLOT_OUT_W = 4;
	localparam int SLOTS_CFG_W = 5;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 8;

	// outcome codes
	localparam logic [1:0] OUT_HIT = 2'd0;
	localparam logic [1:0] OUT_FILL = 2'd1;
	localparam logic [1:0] OUT_REPLACE = 2'd2;
	localparam logic [1:0] OUT_REJECT = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_LIMIT = 4'd1;

	// reset values of the registers
	localparam logic [SLOTS_CFG_W-1:0] SLOTS_RESET = 5'd16;
	localparam logic [PAGE_W-1:0] LIMIT_RESET = 8'd10;

	// one table slot
	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [CNT_W16-1:0] count;
		logic [CNT_W16-1:0] age;
	} entry_t;

	// one result item
	typedef struct packed {
		logic [1:0] outcome;
		logic [SLOT_OUT_W-1:0] slot;
		logic [PAGE_W-1:0] evicted;
		logic [CNT_W16-1:0] count;
	} res_t;

	// saturating increment of a 16-bit counter
	function automatic logic [CNT_W16-1:0] inc_sat(input logic [CNT_W16-1:0] v);
		return (v == '1) ? v : v + 16'd1;
	endfunction

endpackage

>>> hw/rtl/lpt_if.sv
// lpt_if: valid/ready channel interfaces for page references, results and configuration
`timescale 1ns / 1ps

interface lpt_req_if;
	logic valid;
	logic ready;
	logic [lpt_pkg::PAGE_W-1:0] page_number;

	modport source (output valid, output page_number, input ready);
	modport sink (input valid, input page_number, output ready);
endinterface

interface lpt_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] outcome;
	logic [lpt_pkg::SLOT_OUT_W-1:0] slot_index;
	logic [lpt_pkg::PAGE_W-1:0] evicted_page;
	logic [lpt_pkg::CNT_W16-1:0] slot_use_count;

	modport source (output valid, output outcome, output slot_index, output evicted_page,
		output slot_use_count, input ready);
	modport sink (input valid, input outcome, input slot_index, input evicted_page,
		input slot_use_count, output ready);
endinterface

interface lpt_cfg_if;
	logic valid;
	logic ready;
	logic [lpt_pkg::CFG_IDX_W-1:0] index;
	logic [lpt_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/lru_page_table_age_counters_core.sv
// lru_page_table_age_counters_core: top level of the page table with age-counter replacement
// Usage:
//  req carries one page reference per item; rsp returns one result item per
//  reference (outcome, slot index, evicted page, use count after the update).
//  cfg writes slots_in_use (index 0) and page_limit (index 1); it is always
//  ready and should be written only while no reference is in flight.
// Sequencing:
//  a valid reference's result passes from the sequencer's result register
//  to the output register once the scan and update are through: the scan
//  reads one slot per cycle through the single read port of the slot memory,
//  ages it and writes it back, over the n active slots (1 to SLOTS), then the
//  update state writes the hit, filled or victim slot. A rejected reference
//  skips the scan and goes straight to the done state. One reference is
//  worked on at a time; req.ready is high only when the sequencer is idle.
// Reset:
//  arst_n clears all slots to empty (through per-slot valid bits), sets
//  slots_in_use to 16 and page_limit to 10. No clearing pass is needed.
// Stall:
//  the result sits in an output register; if rsp.ready is low the sequencer
//  holds its next result until the register frees up.
`timescale 1ns / 1ps

module lru_page_table_age_counters_core #(
	parameter int SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	lpt_req_if.sink req,
	lpt_rsp_if.source rsp,
	lpt_cfg_if.sink cfg
);
	import lpt_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	logic [SLOTS_CFG_W-1:0] slots_q;
	logic [PAGE_W-1:0] limit_q;
	logic [CNT_W-1:0] n_eff;
	logic out_vld_q;
	res_t out_q;
	logic out_free;
	logic acc;
	logic rej;
	logic idle;
	logic done;
	res_t res;
	logic rd_en;
	logic [IDX_W-1:0] rd_addr;
	entry_t rd_data;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t wr_data;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= SLOTS_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_SLOTS_IN_USE) begin
				slots_q <= cfg.data[SLOTS_CFG_W-1:0];
			end else if (cfg.index == REG_PAGE_LIMIT) begin
				limit_q <= cfg.data;
			end
		end
	end

	// active slot count, clamped to 1..SLOTS
	always_comb begin
		priority if (slots_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(slots_q) > SLOTS) begin
			n_eff = CNT_W'(SLOTS);
		end else begin
			n_eff = CNT_W'(slots_q);
		end
	end

	// input acceptance and page range check
	assign req.ready = idle;
	assign acc = req.valid && idle;
	assign rej = (req.page_number == '0) || (req.page_number > limit_q);

	lpt_mem #(
		.SLOTS(SLOTS),
		.IDX_W(IDX_W)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	lpt_ctrl #(
		.SLOTS(SLOTS),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(acc && !rej),
		.reject(acc && rej),
		.page(req.page_number),
		.n_eff(n_eff),
		.out_free(out_free),
		.rd_data(rd_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.idle(idle),
		.done(done),
		.res(res)
	);

	// output register
	assign out_free = !out_vld_q || rsp.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && done) begin
			out_q <= res;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.outcome = out_q.outcome;
	assign rsp.slot_index = out_q.slot;
	assign rsp.evicted_page = out_q.evicted;
	assign rsp.slot_use_count = out_q.count;

`ifndef ASSERT_OFF
	// the sequencer is busy in the cycle after it accepts an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("sequencer idle right after accepting an item");

	// a rejected item carries no slot, page or count
	a_reject_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.outcome == OUT_REJECT |->
		rsp.slot_index == '0 && rsp.evicted_page == '0 && rsp.slot_use_count == '0)
		else $error("rejected item with nonzero fields");

	// a fill evicts nothing and starts the count at one
	a_fill_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.outcome == OUT_FILL |->
		rsp.evicted_page == '0 && rsp.slot_use_count == 16'd1)
		else $error("fill item with wrong evicted page or count");

	// a replacement always evicts a resident page
	a_replace_victim: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.outcome == OUT_REPLACE |->
		rsp.evicted_page != '0 && rsp.slot_use_count == 16'd1)
		else $error("replacement without a resident victim");
`endif

endmodule

>>> hw/rtl/lpt_mem.sv
// lpt_mem: slot table memory with a registered read and per-slot valid bits
`timescale 1ns / 1ps

module lpt_mem #(
	parameter int SLOTS = 16,
	parameter int IDX_W = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output lpt_pkg::entry_t rd_data,
	input  logic wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  lpt_pkg::entry_t wr_data
);
	import lpt_pkg::*;

	entry_t mem_q [SLOTS];
	logic [SLOTS-1:0] vld_q;
	entry_t rd_q;
	logic rd_vld_q;

	// storage array write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// valid bits, cleared at reset so an unwritten slot reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

>>> hw/rtl/lpt_ctrl.sv
// lpt_ctrl: sequencer that scans and ages the slots, then writes the hit, fill or victim slot
`timescale 1ns / 1ps

module lpt_ctrl #(
	parameter int SLOTS = 16,
	parameter int IDX_W = 4,
	parameter int CNT_W = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic reject,
	input  logic [lpt_pkg::PAGE_W-1:0] page,
	input  logic [CNT_W-1:0] n_eff,
	input  logic out_free,
	input  lpt_pkg::entry_t rd_data,
	output logic rd_en,
	output logic [IDX_W-1:0] rd_addr,
	output logic wr_en,
	output logic [IDX_W-1:0] wr_addr,
	output lpt_pkg::entry_t wr_data,
	output logic idle,
	output logic done,
	output lpt_pkg::res_t res
);
	import lpt_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [CNT_W-1:0] iss_q;
	logic vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [PAGE_W-1:0] page_q;
	logic found_q;
	logic hit_q;
	logic [IDX_W-1:0] tgt_q;
	logic [CNT_W16-1:0] tgt_cnt_q;
	logic [CNT_W16-1:0] max_age_q;
	logic [IDX_W-1:0] max_idx_q;
	logic [PAGE_W-1:0] max_page_q;
	res_t res_q;

	logic occ;
	logic match;
	logic last_s1;
	logic [CNT_W16-1:0] age_new;
	logic [IDX_W-1:0] upd_slot;
	logic [CNT_W16-1:0] upd_cnt;
	logic [1:0] upd_outcome;
	logic [PAGE_W-1:0] upd_evicted;

	// slot read in flight
	assign occ = (rd_data.page != '0);
	assign match = occ && (rd_data.page == page_q);
	assign age_new = occ ? inc_sat(rd_data.age) : rd_data.age;
	assign last_s1 = (CNT_W'(idx_s1) == n_eff - CNT_W'(1));

	// read issue during the scan
	assign rd_en = (state_q == ST_SCAN) && (iss_q < n_eff);
	assign rd_addr = IDX_W'(iss_q);

	// final slot decision
	always_comb begin
		priority if (found_q && hit_q) begin
			upd_outcome = OUT_HIT;
			upd_slot = tgt_q;
			upd_cnt = inc_sat(tgt_cnt_q);
			upd_evicted = '0;
		end else if (found_q) begin
			upd_outcome = OUT_FILL;
			upd_slot = tgt_q;
			upd_cnt = 16'd1;
			upd_evicted = '0;
		end else begin
			upd_outcome = OUT_REPLACE;
			upd_slot = max_idx_q;
			upd_cnt = 16'd1;
			upd_evicted = max_page_q;
		end
	end

	// write port: aging write-back during the scan, slot update afterward
	always_comb begin
		wr_en = 1'b0;
		wr_addr = idx_s1;
		wr_data = '{page: rd_data.page, count: rd_data.count, age: age_new};
		if (state_q == ST_UPDATE) begin
			wr_en = 1'b1;
			wr_addr = upd_slot;
			wr_data = '{page: page_q, count: upd_cnt, age: 16'd1};
		end else if (vld_s1 && occ) begin
			wr_en = 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iss_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					iss_q <= '0;
					if (start) begin
						state_q <= ST_SCAN;
					end else if (reject) begin
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						iss_q <= iss_q + CNT_W'(1);
					end
					if (vld_s1 && last_s1) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// pipeline tag of the read data
	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
	end

	// item page, scan trackers and result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			page_q <= page;
			found_q <= 1'b0;
			hit_q <= 1'b0;
			if (reject) begin
				res_q <= '{outcome: OUT_REJECT, slot: '0, evicted: '0, count: '0};
			end
		end
		if (state_q == ST_SCAN && vld_s1) begin
			// first active slot that is empty or holds the page
			if (!found_q && (!occ || match)) begin
				found_q <= 1'b1;
				hit_q <= match;
				tgt_q <= idx_s1;
				tgt_cnt_q <= rd_data.count;
			end
			// first slot with the largest age after aging
			if (idx_s1 == '0 || age_new > max_age_q) begin
				max_age_q <= age_new;
				max_idx_q <= idx_s1;
				max_page_q <= rd_data.page;
			end
		end
		if (state_q == ST_UPDATE) begin
			res_q <= '{outcome: upd_outcome, slot: SLOT_OUT_W'(upd_slot),
				evicted: upd_evicted, count: upd_cnt};
		end
	end

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign res = res_q;

endmodule
